// File: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/tsrt_pkg.sv
// Shared types and constants of the segment reassembly table.
package tsrt_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] len;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic pop;
      logic flush;
   } store_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PUT_WR,
      ST_CHAIN_RD,
      ST_CHAIN_EV,
      ST_RM_RD,
      ST_RM_EV,
      ST_STAT_RD,
      ST_STAT_EV,
      ST_DONE
   } state_type;

endpackage

// File: hdl/tsrt_store.sv
// Circular entry memory addressed by logical index from the lowest entry.
module tsrt_store #(
   parameter int TABLE_ENTRIES = tsrt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tsrt_pkg::store_ctl_type           ctl,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0] rd_idx,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0] wr_idx,
   input  tsrt_pkg::entry_type               wr_data,
   output tsrt_pkg::entry_type               rd_data
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW:0] DEPTH = (CW+1)'(TABLE_ENTRIES);
   localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

   tsrt_pkg::entry_type mem [TABLE_ENTRIES];
   tsrt_pkg::entry_type rd_data_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW:0]   rd_sum, wr_sum, rd_phys, wr_phys;

   // Map logical index onto the ring.
   always_comb begin
      rd_sum  = (CW+1)'(head_ff) + {1'b0, rd_idx};
      wr_sum  = (CW+1)'(head_ff) + {1'b0, wr_idx};
      rd_phys = (rd_sum >= DEPTH) ? rd_sum - DEPTH : rd_sum;
      wr_phys = (wr_sum >= DEPTH) ? wr_sum - DEPTH : wr_sum;
   end

   always_comb begin
      head_in = head_ff;
      if (ctl.flush) begin
         head_in = '0;
      end else if (ctl.pop) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_phys[AW-1:0]] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_phys[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tcp_segment_reassembly_table_unit.sv
// Top level of the TCP segment reassembly table.
// The block keeps up to TABLE_ENTRIES segment descriptors (key, length) in
// ascending unsigned key order in a single-port-read, single-port-write ring
// memory, plus the next expected sequence number and a running byte total.
// One request is worked at a time by a small sequencer that reads each entry
// in a read state that issues the address, then an evaluate state that
// compares the registered data. An add scans the table, shifts the tail up
// by one entry and, when it lands on the expected number, follows the
// contiguous chain (up to two passes); an add whose key is already present,
// or that meets a full table (flagged as dropped), is not inserted. A
// remove pops lowest entries; a split reinserts the rest by scan and shift.
// Every request ends with a status pass over the contiguous head of the
// table and a final state that posts the result. req_stall stays high from
// acceptance until the result is posted to the output register; a pending
// result waits there without blocking the next request. Writing the csr
// register restarts the expected number and must happen only while the block is idle.
module tcp_segment_reassembly_table_unit #(
   parameter int TABLE_ENTRIES = tsrt_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [31:0]                        csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_operation,
   input  logic [31:0]                        req_seq_num,
   input  logic [15:0]                        req_byte_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_inserted,
   output logic                               rsp_dropped_full,
   output logic [31:0]                        rsp_expected_seq,
   output logic [31:0]                        rsp_bytes_to_read,
   output logic [$clog2(TABLE_ENTRIES+1)-1:0] rsp_packets_to_read,
   output logic                               rsp_missing_segments,
   output logic [$clog2(TABLE_ENTRIES+1)-1:0] rsp_entries_used,
   output logic [31:0]                        rsp_total_bytes
);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

   tsrt_pkg::state_type state_ff, state_in;
   tsrt_pkg::store_ctl_type ctl;
   tsrt_pkg::entry_type rd_data, wr_data;
   logic [CW-1:0] rd_idx, wr_idx;

   logic [31:0]   initial_ff, initial_in;
   logic [31:0]   expected_ff, expected_in;
   logic [31:0]   total_ff, total_in;
   logic [CW-1:0] used_ff, used_in;
   logic [1:0]    op_ff, op_in;
   logic [31:0]   seq_ff, seq_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic          found_ff, found_in;
   logic [31:0]   put_key_ff, put_key_in;
   logic [15:0]   put_len_ff, put_len_in;
   logic [15:0]   removed_ff, removed_in;
   logic [31:0]   run_ff, run_in;
   logic [CW-1:0] pkts_ff, pkts_in;
   logic [31:0]   first_key_ff, first_key_in;
   logic [15:0]   first_len_ff, first_len_in;
   logic          inserted_ff, inserted_in;
   logic          dropped_ff, dropped_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_inserted_ff, rsp_dropped_ff, rsp_missing_ff;
   logic [31:0]   rsp_expected_ff, rsp_bytes_ff, rsp_total_ff;
   logic [CW-1:0] rsp_pkts_ff, rsp_used_ff;
   logic          rsp_load;

   logic          req_xfer;
   logic [32:0]   chain_sum;
   logic [16:0]   rm_sum;
   logic [15:0]   rm_part;
   logic [31:0]   bytes_calc;
   logic [31:0]   span;
   logic          missing_calc;

   tsrt_store #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_idx  (rd_idx),
      .wr_idx  (wr_idx),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != tsrt_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   // Chain and trim arithmetic on the registered memory word.
   assign chain_sum = {1'b0, expected_ff} + {17'b0, rd_data.len};
   assign rm_sum    = {1'b0, removed_ff} + {1'b0, rd_data.len};
   assign rm_part   = cnt_ff - removed_ff;

   // Status word from the summary registers.
   always_comb begin
      bytes_calc = '0;
      if (used_ff != '0) begin
         if (first_key_ff != initial_ff && first_key_ff != expected_ff && used_ff == CW'(1)) begin
            bytes_calc = {16'b0, first_len_ff};
         end else if (expected_ff > first_key_ff) begin
            bytes_calc = expected_ff - first_key_ff;
         end
      end
      span         = expected_ff - initial_ff;
      missing_calc = $signed(total_ff) < $signed(span);
   end

   always_comb begin
      state_in     = state_ff;
      initial_in   = initial_ff;
      expected_in  = expected_ff;
      total_in     = total_ff;
      used_in      = used_ff;
      op_in        = op_ff;
      seq_in       = seq_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      found_in     = found_ff;
      put_key_in   = put_key_ff;
      put_len_in   = put_len_ff;
      removed_in   = removed_ff;
      run_in       = run_ff;
      pkts_in      = pkts_ff;
      first_key_in = first_key_ff;
      first_len_in = first_len_ff;
      inserted_in  = inserted_ff;
      dropped_in   = dropped_ff;
      ctl          = '0;
      rd_idx       = idx_ff;
      wr_idx       = idx_ff;
      wr_data      = rd_data;
      rsp_load     = 1'b0;

      unique case (state_ff)
         tsrt_pkg::ST_IDLE: begin
            if (csr_wr_en) begin
               initial_in  = csr_wr_data;
               expected_in = csr_wr_data;
            end
            if (req_xfer) begin
               op_in       = req_operation;
               seq_in      = req_seq_num;
               cnt_in      = req_byte_count;
               inserted_in = 1'b0;
               dropped_in  = 1'b0;
               idx_in      = '0;
               pkts_in     = '0;
               state_in    = tsrt_pkg::ST_STAT_RD;
               unique case (req_operation)
                  tsrt_pkg::OP_ADD: begin
                     if (req_byte_count != '0) begin
                        put_key_in = req_seq_num;
                        put_len_in = req_byte_count;
                        pos_in     = used_ff;
                        found_in   = 1'b0;
                        state_in   = tsrt_pkg::ST_SCAN_RD;
                     end
                  end
                  tsrt_pkg::OP_REMOVE: begin
                     removed_in = '0;
                     state_in   = tsrt_pkg::ST_RM_RD;
                  end
                  tsrt_pkg::OP_CLEAR: begin
                     used_in   = '0;
                     total_in  = '0;
                     ctl.flush = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Look for the key and the first larger key.
         tsrt_pkg::ST_SCAN_RD: begin
            if (idx_ff == used_ff) begin
               if (found_ff) begin
                  state_in = (op_ff == tsrt_pkg::OP_ADD) ? tsrt_pkg::ST_STAT_RD
                                                         : tsrt_pkg::ST_PUT_WR;
                  idx_in   = '0;
               end else if (used_ff == FULL) begin
                  dropped_in = 1'b1;
                  idx_in     = '0;
                  state_in   = tsrt_pkg::ST_STAT_RD;
               end else begin
                  idx_in   = used_ff;
                  state_in = tsrt_pkg::ST_SHIFT_RD;
               end
            end else begin
               ctl.rd_en = 1'b1;
               state_in  = tsrt_pkg::ST_SCAN_EV;
            end
         end

         tsrt_pkg::ST_SCAN_EV: begin
            if (rd_data.key == put_key_ff) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
            end else if (rd_data.key > put_key_ff && pos_ff == used_ff) begin
               pos_in = idx_ff;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = tsrt_pkg::ST_SCAN_RD;
         end

         // Move the tail up by one entry, top first.
         tsrt_pkg::ST_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = tsrt_pkg::ST_PUT_WR;
            end else begin
               ctl.rd_en = 1'b1;
               rd_idx    = idx_ff - 1'b1;
               state_in  = tsrt_pkg::ST_SHIFT_WR;
            end
         end

         tsrt_pkg::ST_SHIFT_WR: begin
            ctl.wr_en = 1'b1;
            wr_idx    = idx_ff;
            wr_data   = rd_data;
            idx_in    = idx_ff - 1'b1;
            state_in  = tsrt_pkg::ST_SHIFT_RD;
         end

         tsrt_pkg::ST_PUT_WR: begin
            ctl.wr_en   = 1'b1;
            wr_idx      = pos_ff;
            wr_data.key = put_key_ff;
            wr_data.len = put_len_ff;
            if (!found_ff) begin
               used_in = used_ff + 1'b1;
            end
            idx_in   = '0;
            state_in = tsrt_pkg::ST_STAT_RD;
            if (op_ff == tsrt_pkg::OP_ADD) begin
               inserted_in = 1'b1;
               total_in    = total_ff + {16'b0, cnt_ff};
               if (expected_ff == seq_ff) begin
                  expected_in = expected_ff + {16'b0, cnt_ff};
                  state_in    = tsrt_pkg::ST_CHAIN_RD;
               end
            end
         end

         // Advance the expected number across contiguous entries.
         tsrt_pkg::ST_CHAIN_RD: begin
            if (idx_ff == used_ff) begin
               idx_in   = '0;
               state_in = tsrt_pkg::ST_STAT_RD;
            end else begin
               ctl.rd_en = 1'b1;
               state_in  = tsrt_pkg::ST_CHAIN_EV;
            end
         end

         tsrt_pkg::ST_CHAIN_EV: begin
            state_in = tsrt_pkg::ST_CHAIN_RD;
            if (rd_data.key == expected_ff) begin
               expected_in = chain_sum[31:0];
               // Wrapped past zero: restart from the lowest key.
               idx_in      = chain_sum[32] ? '0 : idx_ff + 1'b1;
            end else if (rd_data.key < expected_ff) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               idx_in   = '0;
               state_in = tsrt_pkg::ST_STAT_RD;
            end
         end

         // Trim from the lowest entry.
         tsrt_pkg::ST_RM_RD: begin
            if (removed_ff >= cnt_ff || used_ff == '0) begin
               idx_in   = '0;
               state_in = tsrt_pkg::ST_STAT_RD;
            end else begin
               ctl.rd_en = 1'b1;
               rd_idx    = '0;
               state_in  = tsrt_pkg::ST_RM_EV;
            end
         end

         tsrt_pkg::ST_RM_EV: begin
            ctl.pop = 1'b1;
            used_in = used_ff - 1'b1;
            if (rm_sum <= {1'b0, cnt_ff}) begin
               removed_in = rm_sum[15:0];
               state_in   = tsrt_pkg::ST_RM_RD;
            end else begin
               // Split: reinsert the rest of the lowest entry.
               put_key_in = rd_data.key + {16'b0, rm_part};
               put_len_in = rd_data.len - rm_part;
               removed_in = cnt_ff;
               idx_in     = '0;
               pos_in     = used_ff - 1'b1;
               found_in   = 1'b0;
               state_in   = tsrt_pkg::ST_SCAN_RD;
            end
         end

         // Count contiguous entries from the lowest key.
         tsrt_pkg::ST_STAT_RD: begin
            if (idx_ff == used_ff) begin
               state_in = tsrt_pkg::ST_DONE;
            end else begin
               ctl.rd_en = 1'b1;
               state_in  = tsrt_pkg::ST_STAT_EV;
            end
         end

         tsrt_pkg::ST_STAT_EV: begin
            state_in = tsrt_pkg::ST_STAT_RD;
            if (idx_ff == '0) begin
               first_key_in = rd_data.key;
               first_len_in = rd_data.len;
               run_in       = rd_data.key + {16'b0, rd_data.len};
               pkts_in      = CW'(1);
               idx_in       = CW'(1);
            end else if (rd_data.key == run_ff) begin
               run_in  = run_ff + {16'b0, rd_data.len};
               pkts_in = pkts_ff + 1'b1;
               idx_in  = idx_ff + 1'b1;
            end else begin
               state_in = tsrt_pkg::ST_DONE;
            end
         end

         // Post the result once the output register is free.
         tsrt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = tsrt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tsrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsrt_pkg::ST_IDLE;
         initial_ff   <= '0;
         expected_ff  <= '0;
         total_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         initial_ff   <= initial_in;
         expected_ff  <= expected_in;
         total_ff     <= total_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      seq_ff       <= seq_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      found_ff     <= found_in;
      put_key_ff   <= put_key_in;
      put_len_ff   <= put_len_in;
      removed_ff   <= removed_in;
      run_ff       <= run_in;
      pkts_ff      <= pkts_in;
      first_key_ff <= first_key_in;
      first_len_ff <= first_len_in;
      inserted_ff  <= inserted_in;
      dropped_ff   <= dropped_in;
      if (rsp_load) begin
         rsp_inserted_ff <= inserted_ff;
         rsp_dropped_ff  <= dropped_ff;
         rsp_expected_ff <= expected_ff;
         rsp_bytes_ff    <= bytes_calc;
         rsp_pkts_ff     <= (used_ff == '0) ? '0 : pkts_ff;
         rsp_missing_ff  <= missing_calc;
         rsp_used_ff     <= used_ff;
         rsp_total_ff    <= total_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_inserted         = rsp_inserted_ff;
   assign rsp_dropped_full     = rsp_dropped_ff;
   assign rsp_expected_seq     = rsp_expected_ff;
   assign rsp_bytes_to_read    = rsp_bytes_ff;
   assign rsp_packets_to_read  = rsp_pkts_ff;
   assign rsp_missing_segments = rsp_missing_ff;
   assign rsp_entries_used     = rsp_used_ff;
   assign rsp_total_bytes      = rsp_total_ff;

endmodule

// File: hdl/tsrt_checker.sv
// Port-level checks of the reassembly table, bound to the top level.
`include "assert_macros.svh"

module tsrt_checker #(
   parameter int TABLE_ENTRIES = tsrt_pkg::TABLE_ENTRIES_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_inserted,
   input logic                               rsp_dropped_full,
   input logic [31:0]                        rsp_expected_seq,
   input logic [31:0]                        rsp_bytes_to_read,
   input logic [$clog2(TABLE_ENTRIES+1)-1:0] rsp_packets_to_read,
   input logic [$clog2(TABLE_ENTRIES+1)-1:0] rsp_entries_used,
   input logic [31:0]                        rsp_total_bytes
);
   logic        rsp_held;
   logic        rsp_empty;
   logic [63:0] held_word;

   assign rsp_held  = rsp_valid && rsp_stall;
   assign rsp_empty = rsp_valid && rsp_entries_used == '0;
   assign held_word = {rsp_total_bytes, rsp_expected_seq};

   `ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(held_word))
   `ASSERT_NOW(a_flags_excl, rsp_valid, !(rsp_inserted && rsp_dropped_full))
   `ASSERT_NOW(a_pkts_le_used, rsp_valid, rsp_packets_to_read <= rsp_entries_used)
   `ASSERT_NOW(a_empty_status, rsp_empty, rsp_bytes_to_read == '0 && rsp_packets_to_read == '0)
   `ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

endmodule

bind tcp_segment_reassembly_table_unit tsrt_checker #(
   .TABLE_ENTRIES(TABLE_ENTRIES)
) u_tsrt_checker (.*);
